// File: hdl/best_progenitor_selector_macros.svh
// Assertion macros shared by the selector RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BEST_PROGENITOR_SELECTOR_MACROS_SVH
`define BEST_PROGENITOR_SELECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/bps_pkg.sv
`timescale 1ns / 1ps
// Package for the best progenitor selector: transaction payload types and
// the control word of the shared multiply-accumulate unit. No dependencies.
package bps_pkg;

    typedef struct packed {
        logic [31:0] src_halo_id;
        logic [31:0] src_count;
        logic [31:0] shared_count;
        logic [31:0] cand_halo_id;
        logic [31:0] cand_count;
        logic        end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [31:0] halo_id;
        logic [31:0] progenitor_id;
        logic        last_of_run;
    } t_out_item;

    // Control word for one operation of the shared multiplier.
    typedef struct packed {
        logic       clear;
        logic       issue;
        logic       accum;
        logic       to_r;
        logic [1:0] shift;
    } t_mul_op;

endpackage

// File: hdl/bps_mul_unit.sv
`timescale 1ns / 1ps
// Shared multiplier with a registered product and two wide accumulators.
// Depends on bps_pkg for the operation control word.
module bps_mul_unit
    import bps_pkg::*;
#(
    parameter int CB = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_mul_op         i_op,
    input  logic [CB-1:0]   i_a,
    input  logic [CB-1:0]   i_b,
    output logic [2*CB-1:0] o_prod,
    output logic [4*CB-1:0] o_acc_l,
    output logic [4*CB-1:0] o_acc_r
);

    localparam int PW = 2 * CB;
    localparam int AW = 4 * CB;

    logic [PW-1:0] r_prod;
    logic          r_accum;
    logic          r_to_r;
    logic [1:0]    r_shift;
    logic [AW-1:0] r_acc_l;
    logic [AW-1:0] r_acc_r;
    logic [AW-1:0] w_addend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= 1'b0;
        end else begin
            r_accum <= i_op.issue & i_op.accum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.issue) begin
            r_prod  <= PW'(i_a) * PW'(i_b);
            r_to_r  <= i_op.to_r;
            r_shift <= i_op.shift;
        end
    end

    assign w_addend = AW'(r_prod) << (CB * int'(r_shift));

    always_ff @(posedge i_clk) begin
        if (i_op.clear) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (r_accum) begin
            if (r_to_r) begin
                r_acc_r <= r_acc_r + w_addend;
            end else begin
                r_acc_l <= r_acc_l + w_addend;
            end
        end
    end

    assign o_prod  = r_prod;
    assign o_acc_l = r_acc_l;
    assign o_acc_r = r_acc_r;

endmodule

// File: hdl/best_progenitor_selector.sv
`timescale 1ns / 1ps
// Top level of the best progenitor selector; sequencer, group state and result queue.
// Depends on bps_pkg, bps_mul_unit and best_progenitor_selector_macros.svh.
//
// Records are taken only while idle, so the next waits until this one ends: the
// merit shared^2/(src*cand) and the exact cross-multiplied comparison against
// the kept best need ten products, all issued one per cycle through a single
// COUNT_BITS by COUNT_BITS multiplier, followed by a step that drains the
// accumulator and a decision state. Results wait in a two-entry queue, so the
// next record is taken while they are still unread; a record only holds in
// its decision cycle if results of an earlier record are still queued. A
// group is emitted when a record with a new source id arrives or when
// end_of_stream is set; zero source and candidate counts are treated as one.
`include "best_progenitor_selector_macros.svh"
module best_progenitor_selector
    import bps_pkg::*;
#(
    parameter int ID_BITS    = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    localparam int CB = COUNT_BITS;
    localparam int PW = 2 * CB;
    localparam int AW = 4 * CB;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [3:0] STEP_NUM = 4'd0;
    localparam logic [3:0] STEP_DEN = 4'd1;
    localparam logic [3:0] STEP_END = 4'd10;

    logic [1:0]         r_state;
    logic [3:0]         r_step;

    logic [ID_BITS-1:0] r_src_id;
    logic [ID_BITS-1:0] r_cand_id;
    logic [CB-1:0]      r_src_cnt;
    logic [CB-1:0]      r_shared;
    logic [CB-1:0]      r_cand_cnt;
    logic               r_eos;
    logic [PW-1:0]      r_num;
    logic [PW-1:0]      r_den;

    logic               r_open;
    logic [ID_BITS-1:0] r_gid;
    logic [ID_BITS-1:0] r_best;
    logic [PW-1:0]      r_bnum;
    logic [PW-1:0]      r_bden;

    t_out_item          r_q0;
    t_out_item          r_q1;
    logic [1:0]         r_qcnt;

    t_mul_op            w_op;
    logic [CB-1:0]      w_a;
    logic [CB-1:0]      w_b;
    logic [1:0]         w_idx;
    logic [PW-1:0]      w_prod;
    logic [AW-1:0]      w_acc_l;
    logic [AW-1:0]      w_acc_r;

    logic               w_accept;
    logic               w_pop;
    logic               w_decide;
    logic               w_cont;
    logic               w_greater;
    t_out_item          w_res0;
    t_out_item          w_res1;
    logic [1:0]         w_nres;

    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_qcnt != 2'd0);
    assign o_out_data  = r_q0;
    assign w_pop       = o_out_valid && !i_out_stall;
    assign w_decide    = (r_state == ST_FIN) && (r_qcnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_RUN;
                        r_step  <= STEP_NUM;
                    end
                end
                ST_RUN: begin
                    if (r_step == STEP_END) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                ST_FIN: begin
                    if (w_decide) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_src_id   <= i_in_data.src_halo_id[ID_BITS-1:0];
            r_cand_id  <= i_in_data.cand_halo_id[ID_BITS-1:0];
            r_shared   <= i_in_data.shared_count[CB-1:0];
            r_eos      <= i_in_data.end_of_stream;
            r_src_cnt  <= (i_in_data.src_count[CB-1:0] == '0) ?
                          CB'(1) : i_in_data.src_count[CB-1:0];
            r_cand_cnt <= (i_in_data.cand_count[CB-1:0] == '0) ?
                          CB'(1) : i_in_data.cand_count[CB-1:0];
        end
        if (r_state == ST_RUN && r_step == STEP_DEN) begin
            r_num <= w_prod;
        end
        if (r_state == ST_RUN && r_step == 4'd2) begin
            r_den <= w_prod;
        end
    end

    assign w_idx = r_step[1:0] - 2'd2;

    always_comb begin
        w_op       = '0;
        w_a        = '0;
        w_b        = '0;
        w_op.clear = w_accept;
        if (r_state == ST_RUN) begin
            unique case (r_step)
                4'd0: begin
                    w_op.issue = 1'b1;
                    w_a        = r_shared;
                    w_b        = r_shared;
                end
                4'd1: begin
                    w_op.issue = 1'b1;
                    w_a        = r_src_cnt;
                    w_b        = r_cand_cnt;
                end
                4'd2, 4'd3, 4'd4, 4'd5: begin
                    w_op.issue = 1'b1;
                    w_op.accum = 1'b1;
                    w_op.to_r  = 1'b0;
                    w_op.shift = {1'b0, w_idx[1]} + {1'b0, w_idx[0]};
                    w_a        = w_idx[1] ? r_num[PW-1:CB] : r_num[CB-1:0];
                    w_b        = w_idx[0] ? r_bden[PW-1:CB] : r_bden[CB-1:0];
                end
                4'd6, 4'd7, 4'd8, 4'd9: begin
                    w_op.issue = 1'b1;
                    w_op.accum = 1'b1;
                    w_op.to_r  = 1'b1;
                    w_op.shift = {1'b0, w_idx[1]} + {1'b0, w_idx[0]};
                    w_a        = w_idx[1] ? r_bnum[PW-1:CB] : r_bnum[CB-1:0];
                    w_b        = w_idx[0] ? r_den[PW-1:CB] : r_den[CB-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    bps_mul_unit #(
        .CB (CB)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_prod  (w_prod),
        .o_acc_l (w_acc_l),
        .o_acc_r (w_acc_r)
    );

    assign w_cont    = r_open && (r_src_id == r_gid);
    assign w_greater = (w_acc_l > w_acc_r);

    always_comb begin
        w_res0 = '0;
        w_res1 = '0;
        w_nres = 2'd0;
        if (w_cont) begin
            if (r_eos) begin
                w_res0.halo_id       = 32'(r_gid);
                w_res0.progenitor_id = w_greater ? 32'(r_cand_id) : 32'(r_best);
                w_res0.last_of_run   = 1'b1;
                w_nres               = 2'd1;
            end
        end else if (r_open) begin
            w_res0.halo_id       = 32'(r_gid);
            w_res0.progenitor_id = 32'(r_best);
            w_res0.last_of_run   = !r_eos;
            w_res1.halo_id       = 32'(r_src_id);
            w_res1.progenitor_id = 32'(r_cand_id);
            w_res1.last_of_run   = 1'b1;
            w_nres               = r_eos ? 2'd2 : 2'd1;
        end else if (r_eos) begin
            w_res0.halo_id       = 32'(r_src_id);
            w_res0.progenitor_id = 32'(r_cand_id);
            w_res0.last_of_run   = 1'b1;
            w_nres               = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_gid  <= '0;
            r_best <= '0;
            r_bnum <= '0;
            r_bden <= PW'(1);
        end else if (w_decide) begin
            if (!w_cont || w_greater) begin
                r_best <= r_cand_id;
                r_bnum <= r_num;
                r_bden <= r_den;
            end
            if (!w_cont) begin
                r_gid <= r_src_id;
            end
            r_open <= !r_eos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= 2'd0;
        end else if (w_decide) begin
            r_qcnt <= w_nres;
        end else if (w_pop) begin
            r_qcnt <= r_qcnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_decide) begin
            r_q0 <= w_res0;
            r_q1 <= w_res1;
        end else if (w_pop) begin
            r_q0 <= r_q1;
        end
    end

    `BPS_ASSERT_NEXT(a_accept_starts_run, i_clk, i_rst_n, w_accept,
        (r_state == ST_RUN) && (r_step == STEP_NUM), "Accepted record did not start the sequence.")
    `BPS_ASSERT_NEXT(a_run_ends_in_fin, i_clk, i_rst_n,
        (r_state == ST_RUN) && (r_step == STEP_END), r_state == ST_FIN,
        "Sequencer did not reach the decision cycle.")
    `BPS_ASSERT_NEXT(a_eos_flushes, i_clk, i_rst_n, w_decide && r_eos,
        !r_open && (r_qcnt != 2'd0), "End of stream did not flush the open group.")
    `BPS_ASSERT_NOW(a_pair_order, i_clk, i_rst_n, r_qcnt == 2'd2,
        r_q1.last_of_run && !r_q0.last_of_run, "Queued result pair has wrong last flags.")

endmodule

// File: sim/bps_checker.sv
`timescale 1ns / 1ps
// Checker for the best progenitor selector: watches both channels, predicts the
// finished groups from each accepted overlap record and compares every result.
// Depends on bps_pkg.
module bps_checker
    import bps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    t_out_item   finished_groups[$];
    t_out_item   want;
    logic        grp_open;
    logic [31:0] grp_src_id;
    logic [31:0] best_cand_id;
    logic [63:0] best_num;
    logic [63:0] best_den;
    int          result_no;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        result_no    = 0;
    end

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("%0t: result %0d: %s", $time, result_no, msg);
    endtask

    function automatic logic merit_beats(input logic [63:0] num_a, input logic [63:0] den_a,
                                         input logic [63:0] num_b, input logic [63:0] den_b);
        logic [127:0] lhs;
        logic [127:0] rhs;
        lhs = {64'd0, num_a} * {64'd0, den_b};
        rhs = {64'd0, num_b} * {64'd0, den_a};
        return lhs > rhs;
    endfunction

    task automatic emit_group(input logic last);
        t_out_item res;
        res.halo_id       = grp_src_id;
        res.progenitor_id = best_cand_id;
        res.last_of_run   = last;
        finished_groups.push_back(res);
    endtask

    task automatic select_progenitor(input t_in_item rec);
        logic [63:0] src_n;
        logic [63:0] cand_n;
        logic [63:0] num;
        logic [63:0] den;
        src_n  = (rec.src_count == 32'd0) ? 64'd1 : {32'd0, rec.src_count};
        cand_n = (rec.cand_count == 32'd0) ? 64'd1 : {32'd0, rec.cand_count};
        num    = {32'd0, rec.shared_count} * {32'd0, rec.shared_count};
        den    = src_n * cand_n;
        if (grp_open && rec.src_halo_id == grp_src_id) begin
            if (merit_beats(num, den, best_num, best_den)) begin
                best_cand_id = rec.cand_halo_id;
                best_num     = num;
                best_den     = den;
            end
        end else begin
            if (grp_open) begin
                emit_group(!rec.end_of_stream);
            end
            grp_open     = 1'b1;
            grp_src_id   = rec.src_halo_id;
            best_cand_id = rec.cand_halo_id;
            best_num     = num;
            best_den     = den;
        end
        if (rec.end_of_stream) begin
            emit_group(1'b1);
            grp_open = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            grp_open     = 1'b0;
            grp_src_id   = '0;
            best_cand_id = '0;
            best_num     = 64'd0;
            best_den     = 64'd1;
            finished_groups.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                select_progenitor(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                result_no++;
                if (finished_groups.size() == 0) begin
                    report_mismatch("result arrived with no finished group pending");
                end else begin
                    want = finished_groups.pop_front();
                    if (i_out_data.halo_id !== want.halo_id) begin
                        report_mismatch($sformatf("halo_id %h, expected %h",
                                                  i_out_data.halo_id, want.halo_id));
                    end
                    if (i_out_data.progenitor_id !== want.progenitor_id) begin
                        report_mismatch($sformatf("progenitor_id %h, expected %h",
                                                  i_out_data.progenitor_id, want.progenitor_id));
                    end
                    if (i_out_data.last_of_run !== want.last_of_run) begin
                        report_mismatch($sformatf("last_of_run %b, expected %b",
                                                  i_out_data.last_of_run, want.last_of_run));
                    end
                end
            end
        end
        o_pending = finished_groups.size();
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for the best progenitor selector: clock, reset, overlap record
// stimulus, receiver stalls and the verdict. Depends on bps_pkg, the selector
// RTL and bps_checker.
module tb;
    import bps_pkg::*;

    localparam int N_ITEMS   = 850;
    localparam int CALM_FROM = 750;
    localparam int LONG_HOLD = 300;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in_data;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall;

    int          fail_count;
    int          pending;
    int          items_sent;
    int          next_drain;
    logic        calm;
    logic        hold_req;
    logic        hold_done;
    logic        hold_taken;
    logic [31:0] last_id;
    int          kind;

    best_progenitor_selector u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    bps_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("** best_progenitor_selector: FAILED **");
        $finish;
    end

    function automatic t_in_item overlap_record(input logic [31:0] src_id,
                                                input logic [31:0] src_cnt,
                                                input logic [31:0] shared,
                                                input logic [31:0] cand_id,
                                                input logic [31:0] cand_cnt,
                                                input logic        eos);
        t_in_item r;
        r.src_halo_id   = src_id;
        r.src_count     = src_cnt;
        r.shared_count  = shared;
        r.cand_halo_id  = cand_id;
        r.cand_count    = cand_cnt;
        r.end_of_stream = eos;
        return r;
    endfunction

    function automatic logic [31:0] rand_count(input int bits);
        logic [31:0] v;
        v = $urandom;
        if (bits < 32) begin
            v = v & ((32'd1 << bits) - 32'd1);
        end
        return v;
    endfunction

    task automatic send_record(input t_in_item rec);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= rec;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        items_sent++;
        last_id = rec.src_halo_id;
    endtask

    task automatic send_group();
        logic [31:0] id;
        logic [31:0] src;
        logic [31:0] shared;
        logic [31:0] cand;
        int          len;
        int          bits;
        id   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom;
        len  = $urandom_range(1, 8);
        bits = ($urandom_range(0, 1) == 1) ? 32 : 4 * $urandom_range(1, 7);
        src  = rand_count(bits);
        for (int k = 0; k < len && items_sent < N_ITEMS; k++) begin
            if (k == 0 || $urandom_range(0, 4) != 0) begin
                shared = rand_count(bits);
                cand   = rand_count(bits);
            end
            if ($urandom_range(0, 9) == 0) begin
                src = rand_count(bits);
            end
            send_record(overlap_record(id, src, shared, $urandom, cand,
                                       k == len - 1 && $urandom_range(0, 3) == 0));
        end
    endtask

    // Receiver side: short random stall bursts, plus one long hold-off on request.
    initial begin
        i_out_stall = 1'b0;
        hold_taken  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                i_out_stall <= 1'b1;
                hold_taken   = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        hold_done   = 1'b0;
        items_sent  = 0;
        next_drain  = 150;
        last_id     = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_record(overlap_record(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0));
        send_record(overlap_record(32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 1'b0));
        send_record(overlap_record(32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, 1'b0));
        send_record(overlap_record(32'd0, 32'd4, 32'd2, 32'd5, 32'd1, 1'b0));
        send_record(overlap_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   32'h1234_5678, 32'hFFFF_FFFF, 1'b0));
        send_record(overlap_record(32'hFFFF_FFFF, 32'd1, 32'd1, 32'd9, 32'd1, 1'b0));
        send_record(overlap_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                                   32'hA5A5_A5A5, 32'hFFFF_FFFF, 1'b0));
        send_record(overlap_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   32'h5A5A_5A5A, 32'd1, 1'b0));
        send_record(overlap_record(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF,
                                   32'hC3C3_C3C3, 32'd1, 1'b0));
        send_record(overlap_record(32'hFFFF_FFFF, 32'd1, 32'd0, 32'h3C3C_3C3C, 32'd0, 1'b1));
        send_record(overlap_record(32'd7, 32'd3, 32'd2, 32'd70, 32'd5, 1'b1));
        send_record(overlap_record(32'd8, 32'd10, 32'd3, 32'd80, 32'd10, 1'b0));
        send_record(overlap_record(32'd9, 32'd10, 32'd3, 32'd90, 32'd10, 1'b1));
        send_record(overlap_record(32'd10, 32'd100, 32'd0, 32'd100, 32'd100, 1'b0));
        send_record(overlap_record(32'd10, 32'd100, 32'd1, 32'd101, 32'd200, 1'b0));
        send_record(overlap_record(32'd10, 32'd100, 32'd2, 32'd102, 32'd800, 1'b0));
        send_record(overlap_record(32'd10, 32'd0, 32'd3, 32'd103, 32'd0, 1'b0));
        send_record(overlap_record(32'd11, 32'd50, 32'd0, 32'd110, 32'd50, 1'b0));
        send_record(overlap_record(32'd11, 32'd50, 32'd0, 32'd111, 32'd50, 1'b0));
        send_record(overlap_record(32'd11, 32'd0, 32'd0, 32'd112, 32'd0, 1'b1));
        send_record(overlap_record(32'd11, 32'd5, 32'd5, 32'd113, 32'd5, 1'b0));
        send_record(overlap_record(32'd0, 32'd5, 32'd5, 32'd0, 32'd5, 1'b1));

        while (items_sent < N_ITEMS) begin
            if (items_sent >= CALM_FROM) begin
                calm = 1'b1;
            end
            if (!hold_done && items_sent >= 300) begin
                hold_req  <= 1'b1;
                hold_done  = 1'b1;
            end
            if (items_sent >= next_drain) begin
                next_drain += 400;
                i_in_valid <= 1'b0;
                do @(negedge i_clk); while (pending != 0);
            end
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                send_group();
            end else if (kind == 8) begin
                send_record(overlap_record($urandom, $urandom, $urandom, $urandom, $urandom,
                                           $urandom_range(0, 7) == 0));
            end else begin
                send_record(overlap_record(last_id, $urandom, $urandom, $urandom, $urandom,
                                           $urandom_range(0, 1) == 1));
            end
        end
        send_record(overlap_record($urandom, $urandom, $urandom, $urandom, $urandom, 1'b1));
        i_in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** best_progenitor_selector: PASSED **");
        end else begin
            if (pending != 0) begin
                $display("%0d expected results never arrived", pending);
            end
            $display("** best_progenitor_selector: FAILED **");
        end
        $finish;
    end

endmodule
